### sv/ttlc_pkg.sv
package ttlc_pkg;

  localparam int MAX_TOKEN_LEN = 63;
  localparam int LINE_BITS = 16;
  localparam int OFFSET_BITS = 32;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  localparam int TOK_KIND_W = 3;
  localparam int TOK_LINE_W = 16;
  localparam int TOK_OFFSET_W = 32;
  localparam int TOK_LEN_W = 6;
  localparam int CHAR_W = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

  typedef enum logic [TOK_KIND_W-1:0] {
    TOK_NUMBER = 3'd0,
    TOK_WORD = 3'd1,
    TOK_SYMBOL = 3'd2,
    TOK_NEWLINE = 3'd3,
    TOK_EOI = 3'd4
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_NUM = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  typedef struct packed {
    tok_kind_t kind;
    logic [TOK_LINE_W-1:0] line;
    logic [TOK_LINE_W-1:0] column;
    logic [TOK_OFFSET_W-1:0] offset;
    logic [TOK_LEN_W-1:0] length;
    logic [CHAR_W-1:0] ch;
    logic last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t first;
    tok_t second;
  } lex_out_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

### sv/ttlc_char_if.sv
interface ttlc_char_if;
  logic valid;
  logic ready;
  logic [ttlc_pkg::CHAR_W-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

### sv/ttlc_tok_if.sv
interface ttlc_tok_if;
  logic valid;
  logic ready;
  logic [ttlc_pkg::TOK_KIND_W-1:0] tok_kind;
  logic [ttlc_pkg::TOK_LINE_W-1:0] tok_line;
  logic [ttlc_pkg::TOK_LINE_W-1:0] tok_column;
  logic [ttlc_pkg::TOK_OFFSET_W-1:0] tok_offset;
  logic [ttlc_pkg::TOK_LEN_W-1:0] tok_length;
  logic [ttlc_pkg::CHAR_W-1:0] tok_char;
  logic last_of_run;

  modport source (output valid, output tok_kind, output tok_line, output tok_column,
                  output tok_offset, output tok_length, output tok_char,
                  output last_of_run, input ready);
  modport sink (input valid, input tok_kind, input tok_line, input tok_column,
                input tok_offset, input tok_length, input tok_char,
                input last_of_run, output ready);
endinterface

### sv/ttlc_lexer.sv
module ttlc_lexer (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic [ttlc_pkg::CHAR_W-1:0] ch,
  output ttlc_pkg::lex_out_t res
);

  localparam logic [ttlc_pkg::LINE_BITS-1:0] LINE_TOP = '1;

  ttlc_pkg::mode_t mode, mode_next;
  logic [ttlc_pkg::LEN_W-1:0] plen, plen_next;
  logic [ttlc_pkg::LINE_BITS-1:0] start_line, start_line_next;
  logic [ttlc_pkg::LINE_BITS-1:0] start_column, start_column_next;
  logic [ttlc_pkg::OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [ttlc_pkg::LINE_BITS-1:0] cur_line, cur_line_next;
  logic [ttlc_pkg::LINE_BITS-1:0] cur_column, cur_column_next;
  logic [ttlc_pkg::OFFSET_BITS-1:0] cur_offset, cur_offset_next;

  logic digit, alpha, cont, adv, pend_emit, own_emit;
  logic [ttlc_pkg::LEN_W-1:0] len_inc;
  ttlc_pkg::tok_t pend_tok, own_tok;

  always_comb begin
    digit = ttlc_pkg::is_digit(ch);
    alpha = ttlc_pkg::is_alpha(ch);
    cont = ((mode == ttlc_pkg::MODE_NUM) && digit) ||
           ((mode == ttlc_pkg::MODE_WORD) && (alpha || digit || ch == ttlc_pkg::CH_UNDER));
    len_inc = plen + 1'b1;

    mode_next = mode;
    plen_next = plen;
    start_line_next = start_line;
    start_column_next = start_column;
    start_offset_next = start_offset;
    cur_line_next = cur_line;
    cur_column_next = cur_column;
    cur_offset_next = cur_offset;
    adv = 1'b0;
    pend_emit = 1'b0;
    own_emit = 1'b0;

    pend_tok.kind = (mode == ttlc_pkg::MODE_NUM) ? ttlc_pkg::TOK_NUMBER : ttlc_pkg::TOK_WORD;
    pend_tok.line = ttlc_pkg::TOK_LINE_W'(start_line);
    pend_tok.column = ttlc_pkg::TOK_LINE_W'(start_column);
    pend_tok.offset = ttlc_pkg::TOK_OFFSET_W'(start_offset);
    pend_tok.length = ttlc_pkg::TOK_LEN_W'(cont ? len_inc : plen);
    pend_tok.ch = '0;
    pend_tok.last = 1'b0;

    own_tok.kind = ttlc_pkg::TOK_SYMBOL;
    own_tok.line = ttlc_pkg::TOK_LINE_W'(cur_line);
    own_tok.column = ttlc_pkg::TOK_LINE_W'(cur_column);
    own_tok.offset = ttlc_pkg::TOK_OFFSET_W'(cur_offset);
    own_tok.length = ttlc_pkg::TOK_LEN_W'(1);
    own_tok.ch = ch;
    own_tok.last = 1'b0;

    if (cont) begin
      plen_next = len_inc;
      adv = 1'b1;
      if (len_inc >= ttlc_pkg::LEN_W'(ttlc_pkg::MAX_TOKEN_LEN)) begin
        pend_emit = 1'b1;
        mode_next = ttlc_pkg::MODE_NONE;
        plen_next = '0;
      end
    end else begin
      if (mode != ttlc_pkg::MODE_NONE) begin
        pend_emit = 1'b1;
        mode_next = ttlc_pkg::MODE_NONE;
        plen_next = '0;
      end
      priority if ((ch == ttlc_pkg::CH_SPACE) || (ch == ttlc_pkg::CH_TAB)) begin
        adv = 1'b1;
      end else if (ch == ttlc_pkg::CH_NL) begin
        own_emit = 1'b1;
        own_tok.kind = ttlc_pkg::TOK_NEWLINE;
        cur_line_next = (cur_line == LINE_TOP) ? cur_line : cur_line + 1'b1;
        cur_column_next = ttlc_pkg::LINE_BITS'(1);
        cur_offset_next = cur_offset + 1'b1;
      end else if (ch == ttlc_pkg::CH_NUL) begin
        own_emit = 1'b1;
        own_tok.kind = ttlc_pkg::TOK_EOI;
        own_tok.length = '0;
        own_tok.ch = '0;
        cur_line_next = ttlc_pkg::LINE_BITS'(1);
        cur_column_next = ttlc_pkg::LINE_BITS'(1);
        cur_offset_next = '0;
      end else if (digit || alpha) begin
        mode_next = digit ? ttlc_pkg::MODE_NUM : ttlc_pkg::MODE_WORD;
        plen_next = ttlc_pkg::LEN_W'(1);
        start_line_next = cur_line;
        start_column_next = cur_column;
        start_offset_next = cur_offset;
        adv = 1'b1;
        if (ttlc_pkg::MAX_TOKEN_LEN <= 1) begin
          own_emit = 1'b1;
          own_tok.kind = digit ? ttlc_pkg::TOK_NUMBER : ttlc_pkg::TOK_WORD;
          own_tok.ch = '0;
          mode_next = ttlc_pkg::MODE_NONE;
          plen_next = '0;
        end
      end else begin
        own_emit = 1'b1;
        adv = 1'b1;
      end
    end

    if (adv) begin
      cur_column_next = (cur_column == LINE_TOP) ? cur_column : cur_column + 1'b1;
      cur_offset_next = cur_offset + 1'b1;
    end

    res.count = {1'b0, pend_emit} + {1'b0, own_emit};
    res.second = own_tok;
    res.second.last = 1'b1;
    if (pend_emit) begin
      res.first = pend_tok;
      res.first.last = !own_emit;
    end else begin
      res.first = own_tok;
      res.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ttlc_pkg::MODE_NONE;
      plen <= '0;
      start_line <= ttlc_pkg::LINE_BITS'(1);
      start_column <= ttlc_pkg::LINE_BITS'(1);
      start_offset <= '0;
      cur_line <= ttlc_pkg::LINE_BITS'(1);
      cur_column <= ttlc_pkg::LINE_BITS'(1);
      cur_offset <= '0;
    end else if (step) begin
      mode <= mode_next;
      plen <= plen_next;
      start_line <= start_line_next;
      start_column <= start_column_next;
      start_offset <= start_offset_next;
      cur_line <= cur_line_next;
      cur_column <= cur_column_next;
      cur_offset <= cur_offset_next;
    end
  end

endmodule

### sv/ttlc_tok_fifo.sv
module ttlc_tok_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ttlc_pkg::lex_out_t wr,
  output logic room,
  output logic rd_valid,
  input  logic rd_ready,
  output ttlc_pkg::tok_t rd_tok
);

  ttlc_pkg::tok_t mem [ttlc_pkg::FIFO_DEPTH];
  logic [ttlc_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ttlc_pkg::FIFO_CNT_W-1:0] count;
  logic [1:0] n_push;
  logic pop;

  assign room = count <= ttlc_pkg::FIFO_CNT_W'(ttlc_pkg::FIFO_DEPTH - 2);
  assign rd_valid = count != '0;
  assign rd_tok = mem[rd_ptr];
  assign pop = rd_valid && rd_ready;
  assign n_push = push ? wr.count : 2'd0;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= wr.first;
    end
    if (n_push == 2'd2) begin
      mem[ttlc_pkg::FIFO_PTR_W'(wr_ptr + 1'b1)] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= ttlc_pkg::FIFO_PTR_W'(wr_ptr + n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ttlc_pkg::FIFO_CNT_W'(n_push) - ttlc_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

### sv/text_tokenizer_line_column.sv
// Streaming tokenizer: one text byte per word on chars, tokens (number, word,
// symbol, newline, end of input) with start line, column, offset and length on
// tokens. A byte is taken every clock as long as the four-entry token queue has
// room for two more tokens; a byte lands in an input register and is lexed from
// there once the queue has room, its tokens going into the queue and from there
// to tokens. A byte yields zero, one or two tokens, and the token port drains
// one per cycle, so input runs at one byte per clock while each byte yields at
// most one token and tokens are taken every cycle; a run of two-token bytes or a
// stalled token port fills the queue and holds input until it drains back to two
// entries. last_of_run marks the final token of each byte. Lines and columns
// start at 1 and saturate; a zero byte closes any pending token, emits end of
// input and rewinds the position.
module text_tokenizer_line_column (
  input  logic clk,
  input  logic rst,
  ttlc_char_if.sink chars,
  ttlc_tok_if.source tokens
);

  logic in_vld;
  logic [ttlc_pkg::CHAR_W-1:0] in_byte;
  logic room, lex_take;
  ttlc_pkg::lex_out_t lx;
  ttlc_pkg::tok_t head;

  assign lex_take = in_vld && room;
  assign chars.ready = !in_vld || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (chars.ready) begin
      in_vld <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_byte <= chars.in_char;
    end
  end

  ttlc_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (lex_take),
    .ch   (in_byte),
    .res  (lx)
  );

  ttlc_tok_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (lex_take),
    .wr       (lx),
    .room     (room),
    .rd_valid (tokens.valid),
    .rd_ready (tokens.ready),
    .rd_tok   (head)
  );

  assign tokens.tok_kind = head.kind;
  assign tokens.tok_line = head.line;
  assign tokens.tok_column = head.column;
  assign tokens.tok_offset = head.offset;
  assign tokens.tok_length = head.length;
  assign tokens.tok_char = head.ch;
  assign tokens.last_of_run = head.last;

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.ready |=> in_vld)
    else $error("accepted byte not held in input register");

  a_pair_marks: assert property (@(posedge clk) disable iff (rst)
    lex_take && lx.count == 2'd2 |-> !lx.first.last && lx.second.last)
    else $error("two-token step with wrong last marks");

  a_single_mark: assert property (@(posedge clk) disable iff (rst)
    lex_take && lx.count == 2'd1 |-> lx.first.last)
    else $error("single-token step not marked last");

  a_nul_emits: assert property (@(posedge clk) disable iff (rst)
    lex_take && in_byte == ttlc_pkg::CH_NUL |-> lx.count != 2'd0)
    else $error("zero byte produced no end-of-input token");

endmodule
